@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the vector normalizer.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define V3N_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: check failed");
// Check that a condition implies a consequence in the same cycle.
`define V3N_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
`else
`define V3N_ASSERT(lbl, clk, rstn, prop)
`define V3N_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/v3n_pkg.sv @@
// Types and constants of the vector normalizer pipeline.
// No dependencies; used by v3n_root_step and the top level.
package v3n_pkg;

    localparam int CompW  = 15;
    localparam int LenW   = 14;
    localparam int MagW   = 15;
    localparam int SqW    = 29;
    localparam int SumW   = 30;
    localparam int ProdW  = 28;
    localparam int LimW   = 56;
    localparam int AccW   = 44;
    localparam int QuoW   = 14;
    localparam int CostW  = 60;
    localparam int Steps  = 14;
    localparam logic [LenW-1:0] LenReset = 14'd4096;

    // Per-component state of the restoring square-root style search.
    typedef struct packed {
        logic [LimW-1:0] rem;   // (mag*L)^2 - q^2*S
        logic [AccW-1:0] acc;   // q*S
        logic [QuoW-1:0] quo;   // bits of q found so far
        logic            neg;
    } t_comp;

    typedef struct packed {
        logic [1:0]      row;
        logic            zero;
        logic [SumW-1:0] sum;
        t_comp [2:0]     comp;
    } t_item;

endpackage

@@ hw/rtl/vec3_normalize_to_length_unit.sv @@
// Top level of the vector normalizer: scales a signed 3-vector to length L.
// Depends on v3n_pkg, v3n_root_step and assert_macros.svh.
//
//   channel   direction  signals                         word
//   input     slave      i_s_tvalid/o_s_tready/i_s_tdata row, x, y, z
//   result    master     o_m_tvalid/i_m_tready/o_m_tdata rows, norm x/y/z; tuser zero flag
//   config    slave      i_cfg_valid/o_cfg_ready         target length
//
// One word enters per cycle while the pipeline advances; each result passes through four
// stages of capture, squaring and products, then the 14-stage bit search of the scaled
// magnitude, one quotient bit per stage, and then the output register.
// The whole pipeline advances when the output register is empty or being taken;
// on a stall every stage holds, so nothing is dropped or repeated.
// Reset (synchronous, active low) clears valid bits and loads L = 4096.
module vec3_normalize_to_length_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: row_select[1:0], comp_x[16:2], comp_y[31:17], comp_z[46:32]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,
    // tdata: first_row[1:0], second_row[4:2], norm_x[19:5], norm_y[34:20],
    //        norm_z[49:35]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,
    // tuser: zero_length[0]
    output logic [0:0]  o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_data
);

    localparam int Steps = v3n_pkg::Steps;

    logic adv;

    // Target length register.
    logic [v3n_pkg::LenW-1:0] r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= v3n_pkg::LenReset;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Stage 0: capture the word.
    logic                     r0_vld;
    logic [1:0]               r0_row;
    logic [v3n_pkg::CompW-1:0] r0_c [3];

    // Stage 1: magnitudes and squares.
    logic                     r1_vld;
    logic [1:0]               r1_row;
    logic [2:0]               r1_neg;
    logic [v3n_pkg::MagW-1:0] r1_mag [3];
    logic [v3n_pkg::SqW-1:0]  r1_sq [3];

    // Stage 2: sum of squares and mag*L.
    logic                      r2_vld;
    logic [1:0]                r2_row;
    logic [2:0]                r2_neg;
    logic [v3n_pkg::SumW-1:0]  r2_sum;
    logic [v3n_pkg::ProdW-1:0] r2_p [3];

    // Stage 3: (mag*L)^2 seeds the search remainders.
    logic           r3_vld;
    v3n_pkg::t_item r3_item;

    // Output register.
    logic        r_out_vld;
    logic [55:0] r_out_data;
    logic        r_out_zero;

    assign adv        = !r_out_vld || i_m_tready;
    assign o_s_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
        end else if (adv) begin
            r0_vld    <= i_s_tvalid;
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_row  <= i_s_tdata[1:0];
            r0_c[0] <= i_s_tdata[16:2];
            r0_c[1] <= i_s_tdata[31:17];
            r0_c[2] <= i_s_tdata[46:32];
        end
    end

    // Take the magnitude of each component and square it.
    always_ff @(posedge i_clk) begin
        logic [v3n_pkg::MagW-1:0] mag;
        if (adv) begin
            r1_row <= r0_row;
            for (int i = 0; i < 3; i++) begin
                mag = r0_c[i][v3n_pkg::CompW-1] ? (v3n_pkg::MagW)'(-r0_c[i]) : r0_c[i];
                r1_neg[i] <= r0_c[i][v3n_pkg::CompW-1];
                r1_mag[i] <= mag;
                r1_sq[i]  <= v3n_pkg::SqW'({14'd0, mag} * {14'd0, mag});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_row <= r1_row;
            r2_neg <= r1_neg;
            r2_sum <= v3n_pkg::SumW'({1'b0, r1_sq[0]}) + v3n_pkg::SumW'({1'b0, r1_sq[1]})
                    + v3n_pkg::SumW'({1'b0, r1_sq[2]});
            for (int i = 0; i < 3; i++) begin
                r2_p[i] <= v3n_pkg::ProdW'({14'd0, r1_mag[i]} * {15'd0, r_len});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_item.row  <= r2_row;
            r3_item.zero <= (r2_sum == '0);
            r3_item.sum  <= r2_sum;
            for (int i = 0; i < 3; i++) begin
                r3_item.comp[i].rem <= v3n_pkg::LimW'({28'd0, r2_p[i]} * {28'd0, r2_p[i]});
                r3_item.comp[i].acc <= '0;
                r3_item.comp[i].quo <= '0;
                r3_item.comp[i].neg <= r2_neg[i];
            end
        end
    end

    // Bit search: one quotient bit per stage, most significant first.
    logic           stg_vld  [Steps+1];
    v3n_pkg::t_item stg_item [Steps+1];

    assign stg_vld[0]  = r3_vld;
    assign stg_item[0] = r3_item;

    for (genvar j = 0; j < Steps; j++) begin : g_step
        v3n_root_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_shift (4'(Steps - 1 - j)),
            .i_valid (stg_vld[j]),
            .i_item  (stg_item[j]),
            .o_valid (stg_vld[j+1]),
            .o_item  (stg_item[j+1])
        );
    end

    // Apply signs, force zeros for a zero-length vector, pack the word.
    logic [v3n_pkg::CompW-1:0] n_norm [3];
    logic [55:0]               n_out_data;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (stg_item[Steps].zero) begin
                n_norm[i] = '0;
            end else if (stg_item[Steps].comp[i].neg) begin
                n_norm[i] = v3n_pkg::CompW'(-{1'b0, stg_item[Steps].comp[i].quo});
            end else begin
                n_norm[i] = {1'b0, stg_item[Steps].comp[i].quo};
            end
        end
        n_out_data = {6'd0, n_norm[2], n_norm[1], n_norm[0],
                      3'({1'b0, stg_item[Steps].row} + 3'd2), stg_item[Steps].row};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= stg_vld[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
            r_out_zero <= stg_item[Steps].zero;
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_zero;

    // Checks.
    logic [v3n_pkg::CompW-1:0] chk_abs_x;
    assign chk_abs_x = r_out_data[19] ? v3n_pkg::CompW'(-r_out_data[19:5]) : r_out_data[19:5];

`include "assert_macros.svh"

    `V3N_ASSERT_IMPL(a_zero_clears, i_clk, i_rst_n, r_out_vld && r_out_zero, r_out_data[49:5] == '0)
    `V3N_ASSERT_IMPL(a_rows, i_clk, i_rst_n, r_out_vld, r_out_data[4:2] == 3'({1'b0, r_out_data[1:0]} + 3'd2))
    `V3N_ASSERT_IMPL(a_bound, i_clk, i_rst_n, r_out_vld && !r_out_zero, chk_abs_x <= {1'b0, r_len})

endmodule

@@ hw/rtl/v3n_root_step.sv @@
// One bit of the quotient search for all three components, registered.
// Depends on v3n_pkg.
module v3n_root_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [3:0]      i_shift,
    input  logic            i_valid,
    input  v3n_pkg::t_item  i_item,
    output logic            o_valid,
    output v3n_pkg::t_item  o_item
);

    logic           r_valid;
    v3n_pkg::t_item r_item;
    v3n_pkg::t_item n_item;

    // Try q + 2^k: accept when (2*q*S + 2^k*S) * 2^k fits in the remainder.
    always_comb begin
        logic [v3n_pkg::CostW-1:0] cost;
        n_item = i_item;
        for (int i = 0; i < 3; i++) begin
            cost = ({(v3n_pkg::CostW - v3n_pkg::AccW)'(0), i_item.comp[i].acc}
                        << ({1'b0, i_shift} + 5'd1))
                 + ({(v3n_pkg::CostW - v3n_pkg::SumW)'(0), i_item.sum}
                        << ({1'b0, i_shift} << 1));
            if (cost <= {(v3n_pkg::CostW - v3n_pkg::LimW)'(0), i_item.comp[i].rem}) begin
                n_item.comp[i].rem = i_item.comp[i].rem - cost[v3n_pkg::LimW-1:0];
                n_item.comp[i].acc = i_item.comp[i].acc
                    + ({(v3n_pkg::AccW - v3n_pkg::SumW)'(0), i_item.sum} << i_shift);
                n_item.comp[i].quo = i_item.comp[i].quo
                    | (v3n_pkg::QuoW'(1) << i_shift);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
